@@ hdl/haar_feature_evaluator_defines.svh @@
// Assertion macros used by the bound checker module haar_checker.
`ifndef HAAR_FEATURE_EVALUATOR_DEFINES_SVH
`define HAAR_FEATURE_EVALUATOR_DEFINES_SVH

// Consequent checked in the same cycle as the antecedent.
`define HAAR_ASSERT_SAME(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("haar checker: same-cycle check failed");

// Consequent checked in the cycle after the antecedent.
`define HAAR_ASSERT_NEXT(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("haar checker: next-cycle check failed");

`endif

@@ hdl/haar_pkg.sv @@
package haar_pkg;

  // default sizes
  localparam int DEF_MAX_WIDTH  = 64;
  localparam int DEF_MAX_HEIGHT = 64;
  localparam int DEF_SUM_BITS   = 24;

  // field widths
  localparam int IDX_W    = 12;
  localparam int VAL_IN_W = 24;
  localparam int TYPE_W   = 3;
  localparam int OFS_W    = 6;
  localparam int SIZE_W   = 7;
  localparam int FV_W     = 26;
  localparam int STATUS_W = 2;
  localparam int IN_DATA_W  = 80;
  localparam int OUT_DATA_W = 32;

  // config port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 7;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;
  localparam logic [CFG_DATA_W-1:0] IMAGE_SIZE_RST  = 7'd64;

  // item kinds
  localparam logic KIND_WRITE = 1'b0;
  localparam logic KIND_EVAL  = 1'b1;

  // feature types
  localparam logic [TYPE_W-1:0] FT_VERT2  = 3'd0;
  localparam logic [TYPE_W-1:0] FT_HORIZ2 = 3'd1;
  localparam logic [TYPE_W-1:0] FT_VERT3  = 3'd2;
  localparam logic [TYPE_W-1:0] FT_HORIZ3 = 3'd3;
  localparam logic [TYPE_W-1:0] FT_CROSS  = 3'd4;

  // result status
  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_INVALID = 2'd1;
  localparam logic [STATUS_W-1:0] ST_OUTSIDE = 2'd2;

  localparam int VALUE_MAX = 33554431;
  localparam int VALUE_MIN = -33554432;

  // 16 corners: 4 rectangles x 4 corners
  localparam int CORNER_W = 4;

  typedef struct packed {
    logic                capture;
    logic                wr_en;
    logic                setup;
    logic                rd_en;
    logic [CORNER_W-1:0] corner;
    logic                acc_en;
    logic                out_load;
  } haar_cmd_t;

  typedef struct packed {
    logic error;
  } haar_sts_t;

endpackage

@@ hdl/haar_ctrl.sv @@
module haar_ctrl
  import haar_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  input  logic      in_kind,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  output haar_cmd_t cmd,
  input  haar_sts_t sts
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SETUP,
    S_READ,
    S_DRAIN,
    S_DONE
  } state_t;

  state_t              state;
  logic [CORNER_W-1:0] cnt;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd          = '0;
    cmd.capture  = (state == S_IDLE) && in_valid && (in_kind == KIND_EVAL);
    cmd.wr_en    = (state == S_IDLE) && in_valid && (in_kind == KIND_WRITE);
    cmd.setup    = (state == S_SETUP);
    cmd.rd_en    = (state == S_READ);
    cmd.corner   = cnt;
    // read data lands in the cycle after the address
    cmd.acc_en   = ((state == S_READ) && (cnt != '0)) || (state == S_DRAIN);
    cmd.out_load = (state == S_DONE) && (!out_valid || out_ready);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (cmd.capture) begin
            state <= S_SETUP;
          end
        end
        S_SETUP: begin
          cnt <= '0;
          if (sts.error) begin
            state <= S_DONE;
          end else begin
            state <= S_READ;
          end
        end
        S_READ: begin
          cnt <= cnt + 1'b1;
          if (cnt == '1) begin
            state <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          state <= S_DONE;
        end
        S_DONE: begin
          if (cmd.out_load) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

@@ hdl/haar_datapath.sv @@
module haar_datapath
  import haar_pkg::*;
#(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
  parameter int SUM_BITS   = DEF_SUM_BITS
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [CFG_IDX_W-1:0]       cfg_index,
  input  logic [CFG_DATA_W-1:0]      cfg_data,
  input  logic [IDX_W-1:0]           entry_index,
  input  logic [VAL_IN_W-1:0]        entry_value,
  input  logic [TYPE_W-1:0]          feat_type,
  input  logic [OFS_W-1:0]           feat_x,
  input  logic [OFS_W-1:0]           feat_y,
  input  logic [SIZE_W-1:0]          feat_w,
  input  logic [SIZE_W-1:0]          feat_h,
  input  logic [OFS_W-1:0]           pos_x,
  input  logic [OFS_W-1:0]           pos_y,
  input  haar_cmd_t                  cmd,
  output haar_sts_t                  sts,
  output logic signed [FV_W-1:0]     feature_value,
  output logic [STATUS_W-1:0]        status
);

  localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW     = $clog2(DEPTH);
  localparam int CW     = (AW > 16) ? AW : 16;
  localparam int ACC_W  = (SUM_BITS + 6 > FV_W + 1) ? SUM_BITS + 6 : FV_W + 1;
  localparam logic signed [ACC_W-1:0] SAT_MAX = ACC_W'(VALUE_MAX);
  localparam logic signed [ACC_W-1:0] SAT_MIN = ACC_W'(VALUE_MIN);
  localparam logic [12:0] RECIP3 = 13'd43;  // w/3 == (w*43)>>7 for w < 128

  typedef struct packed {
    logic       active;
    logic       neg;
    logic [1:0] ax;
    logic [1:0] ay;
  } rect_t;

  // rectangle r of a feature: offset in part widths/heights and its sign
  function automatic rect_t rect_of(logic [TYPE_W-1:0] ft, logic [1:0] r);
    rect_t rc;
    rc = '0;
    unique case (ft)
      FT_VERT2: begin
        rc.active = (r < 2'd2);
        rc.neg    = (r == 2'd1);
        rc.ax     = (r == 2'd1) ? 2'd1 : 2'd0;
      end
      FT_HORIZ2: begin
        rc.active = (r < 2'd2);
        rc.neg    = (r == 2'd1);
        rc.ay     = (r == 2'd1) ? 2'd1 : 2'd0;
      end
      FT_VERT3: begin
        // centre first, then the two sides
        rc.active = (r < 2'd3);
        rc.neg    = (r != 2'd0);
        rc.ax     = (r == 2'd0) ? 2'd1 : ((r == 2'd2) ? 2'd2 : 2'd0);
      end
      FT_HORIZ3: begin
        rc.active = (r < 2'd3);
        rc.neg    = (r != 2'd0);
        rc.ay     = (r == 2'd0) ? 2'd1 : ((r == 2'd2) ? 2'd2 : 2'd0);
      end
      FT_CROSS: begin
        // diagonals positive, anti-diagonals negative
        rc.active = 1'b1;
        rc.neg    = r[1];
        rc.ax     = {1'b0, r[0] ^ r[1]};
        rc.ay     = {1'b0, r[0]};
      end
      default: begin
        rc = '0;
      end
    endcase
    return rc;
  endfunction

  // configuration
  logic [CFG_DATA_W-1:0] image_width;
  logic [CFG_DATA_W-1:0] image_height;
  logic [CFG_DATA_W-1:0] eff_w;
  logic [CFG_DATA_W-1:0] eff_h;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= IMAGE_SIZE_RST;
      image_height <= IMAGE_SIZE_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_IMAGE_WIDTH:  image_width  <= cfg_data;
        REG_IMAGE_HEIGHT: image_height <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  assign eff_w = (32'(image_width) < 32'(MAX_WIDTH)) ? image_width
                                                      : CFG_DATA_W'(MAX_WIDTH);
  assign eff_h = (32'(image_height) < 32'(MAX_HEIGHT)) ? image_height
                                                        : CFG_DATA_W'(MAX_HEIGHT);

  // captured evaluate word
  logic [TYPE_W-1:0] type_q;
  logic [SIZE_W-1:0] x0_q, y0_q, w_q, h_q;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      type_q <= feat_type;
      x0_q   <= SIZE_W'(pos_x) + SIZE_W'(feat_x);
      y0_q   <= SIZE_W'(pos_y) + SIZE_W'(feat_y);
      w_q    <= feat_w;
      h_q    <= feat_h;
    end
  end

  // part sizes, spans and bounds check
  logic [12:0]         w_by3, h_by3;
  logic [SIZE_W-1:0]   dx, dy, rw, rh;
  logic [SIZE_W:0]     span_w, span_h;
  logic [SIZE_W+1:0]   end_x, end_y;
  logic [STATUS_W-1:0] status_c;

  assign w_by3 = 13'(w_q) * RECIP3;
  assign h_by3 = 13'(h_q) * RECIP3;

  always_comb begin
    dx     = w_q;
    dy     = h_q;
    span_w = (SIZE_W+1)'(w_q);
    span_h = (SIZE_W+1)'(h_q);
    unique case (type_q)
      FT_VERT2: begin
        dx     = w_q >> 1;
        span_w = (SIZE_W+1)'(dx) << 1;
      end
      FT_HORIZ2: begin
        dy     = h_q >> 1;
        span_h = (SIZE_W+1)'(dy) << 1;
      end
      FT_VERT3: begin
        dx     = SIZE_W'(w_by3[12:7]);
        span_w = (SIZE_W+1)'(dx) + ((SIZE_W+1)'(dx) << 1);
      end
      FT_HORIZ3: begin
        dy     = SIZE_W'(h_by3[12:7]);
        span_h = (SIZE_W+1)'(dy) + ((SIZE_W+1)'(dy) << 1);
      end
      default: begin
        dx     = w_q >> 1;
        dy     = h_q >> 1;
        span_w = (SIZE_W+1)'(dx) << 1;
        span_h = (SIZE_W+1)'(dy) << 1;
      end
    endcase
    rw = ((type_q == FT_HORIZ2) || (type_q == FT_HORIZ3)) ? w_q : dx;
    rh = ((type_q == FT_VERT2) || (type_q == FT_VERT3)) ? h_q : dy;
  end

  assign end_x = (SIZE_W+2)'(x0_q) + (SIZE_W+2)'(span_w);
  assign end_y = (SIZE_W+2)'(y0_q) + (SIZE_W+2)'(span_h);

  always_comb begin
    if (type_q > FT_CROSS) begin
      status_c = ST_INVALID;
    end else if ((end_x > (SIZE_W+2)'(eff_w)) || (end_y > (SIZE_W+2)'(eff_h))) begin
      status_c = ST_OUTSIDE;
    end else begin
      status_c = ST_OK;
    end
  end

  assign sts.error = (status_c != ST_OK);

  logic [SIZE_W-1:0]   dx_q, dy_q, rw_q, rh_q;
  logic [STATUS_W-1:0] status_q;

  always_ff @(posedge clk) begin
    if (cmd.setup) begin
      dx_q     <= dx;
      dy_q     <= dy;
      rw_q     <= rw;
      rh_q     <= rh;
      status_q <= status_c;
    end
  end

  // corner address for the current step
  rect_t             rect;
  logic [SIZE_W:0]   off_x, off_y, rx, ry;
  logic [SIZE_W:0]   row_hi, col_hi, row_lo, col_lo, row, col;
  logic              corner_use, corner_neg, term_ok, term_neg;
  logic [CW-1:0]     addr_full;
  logic [AW-1:0]     rd_addr;

  assign rect = rect_of(type_q, cmd.corner[3:2]);

  always_comb begin
    unique case (rect.ax)
      2'd1:    off_x = (SIZE_W+1)'(dx_q);
      2'd2:    off_x = (SIZE_W+1)'(dx_q) << 1;
      default: off_x = '0;
    endcase
    unique case (rect.ay)
      2'd1:    off_y = (SIZE_W+1)'(dy_q);
      2'd2:    off_y = (SIZE_W+1)'(dy_q) << 1;
      default: off_y = '0;
    endcase
  end

  assign rx     = (SIZE_W+1)'(x0_q) + off_x;
  assign ry     = (SIZE_W+1)'(y0_q) + off_y;
  assign row_hi = ry + (SIZE_W+1)'(rh_q) - 1'b1;
  assign col_hi = rx + (SIZE_W+1)'(rw_q) - 1'b1;
  assign row_lo = ry - 1'b1;
  assign col_lo = rx - 1'b1;

  always_comb begin
    unique case (cmd.corner[1:0])
      2'd0: begin
        row = row_hi; col = col_hi; corner_use = 1'b1; corner_neg = 1'b0;
      end
      2'd1: begin
        row = row_hi; col = col_lo; corner_use = (rx != '0); corner_neg = 1'b1;
      end
      2'd2: begin
        row = row_lo; col = col_hi; corner_use = (ry != '0); corner_neg = 1'b1;
      end
      default: begin
        row = row_lo; col = col_lo;
        corner_use = (rx != '0) && (ry != '0); corner_neg = 1'b0;
      end
    endcase
  end

  // empty parts contribute nothing
  assign term_ok  = rect.active && (rw_q != '0) && (rh_q != '0) && corner_use;
  assign term_neg = corner_neg ^ rect.neg;

  assign addr_full = CW'(row) * CW'(eff_w) + CW'(col);
  assign rd_addr   = AW'(addr_full);

  // integral store, single port
  logic [SUM_BITS-1:0] store [DEPTH];
  logic [SUM_BITS-1:0] rd_data;
  logic [AW-1:0]       mem_addr;
  logic                wr_hit;

  assign wr_hit   = cmd.wr_en && (32'(entry_index) < 32'(DEPTH));
  assign mem_addr = cmd.wr_en ? AW'(entry_index) : rd_addr;

  always_ff @(posedge clk) begin
    if (wr_hit) begin
      store[mem_addr] <= SUM_BITS'(entry_value);
    end
    if (cmd.rd_en) begin
      rd_data <= store[mem_addr];
    end
  end

  logic term_ok_q, term_neg_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      term_ok_q  <= 1'b0;
      term_neg_q <= 1'b0;
    end else if (cmd.rd_en) begin
      term_ok_q  <= term_ok;
      term_neg_q <= term_neg;
    end
  end

  // accumulate signed corner terms
  logic signed [ACC_W-1:0] acc;
  logic signed [ACC_W-1:0] term;

  assign term = $signed(ACC_W'(rd_data));

  always_ff @(posedge clk) begin
    if (cmd.setup) begin
      acc <= '0;
    end else if (cmd.acc_en && term_ok_q) begin
      if (term_neg_q) begin
        acc <= acc - term;
      end else begin
        acc <= acc + term;
      end
    end
  end

  // result register
  logic signed [FV_W-1:0] sat_val;

  always_comb begin
    if (acc > SAT_MAX) begin
      sat_val = FV_W'(VALUE_MAX);
    end else if (acc < SAT_MIN) begin
      sat_val = FV_W'(VALUE_MIN);
    end else begin
      sat_val = acc[FV_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      feature_value <= (status_q == ST_OK) ? sat_val : '0;
      status        <= status_q;
    end
  end

endmodule

@@ hdl/haar_feature_evaluator.sv @@
// Haar-like feature evaluator over an integral image.
// Input stream: s_axis_tuser selects the word kind. A write word stores one
// integral image entry at entry_index; an evaluate word names a feature and
// returns one result word on the output stream. Writes give no result.
// Config: cfg_we/cfg_index/cfg_data set image_width (0) and image_height (1);
// write them only while the block is idle.
// Throughput: a write word is taken every cycle while the block is idle. An
// evaluate word holds the input until its result is loaded: a setup step, 16
// corner reads from the single-port store (one per cycle), a drain step for
// the last read, and a done step that loads the result. A word rejected for
// an unknown type or a rectangle outside the image goes from setup straight to the done step.
// Output: one result register. While it waits on m_axis_tready, the block
// still takes new words; an evaluate word that finishes meanwhile holds in its
// last cycle until the register frees up.
// Reset: rst (synchronous) empties the output, returns the controller to idle
// and sets both image registers to 64. Store contents are not cleared; read
// only entries that have been written.
module haar_feature_evaluator
  import haar_pkg::*;
#(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
  parameter int SUM_BITS   = DEF_SUM_BITS
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // entry_index, entry_value, feat_type, feat_x, feat_y, feat_w, feat_h,
  // pos_x, pos_y, zero pad
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  input  logic                  s_axis_tuser,  // kind
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0] m_axis_tdata,  // feature_value, status, zero pad
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  haar_cmd_t              cmd;
  haar_sts_t              sts;
  logic signed [FV_W-1:0] feature_value;
  logic [STATUS_W-1:0]    status;

  haar_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_kind   (s_axis_tuser),
    .in_ready  (s_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .cmd       (cmd),
    .sts       (sts)
  );

  haar_datapath #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .SUM_BITS   (SUM_BITS)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .entry_index   (s_axis_tdata[11:0]),
    .entry_value   (s_axis_tdata[35:12]),
    .feat_type     (s_axis_tdata[38:36]),
    .feat_x        (s_axis_tdata[44:39]),
    .feat_y        (s_axis_tdata[50:45]),
    .feat_w        (s_axis_tdata[57:51]),
    .feat_h        (s_axis_tdata[64:58]),
    .pos_x         (s_axis_tdata[70:65]),
    .pos_y         (s_axis_tdata[76:71]),
    .cmd           (cmd),
    .sts           (sts),
    .feature_value (feature_value),
    .status        (status)
  );

  assign m_axis_tdata = {(OUT_DATA_W - FV_W - STATUS_W)'(0), status, feature_value};

endmodule

@@ hdl/haar_checker.sv @@
`include "haar_feature_evaluator_defines.svh"

module haar_checker
  import haar_pkg::*;
(
  input logic                  clk,
  input logic                  rst,
  input logic                  s_axis_tvalid,
  input logic                  s_axis_tready,
  input logic                  s_axis_tuser,
  input logic                  m_axis_tvalid,
  input logic                  m_axis_tready,
  input logic [OUT_DATA_W-1:0] m_axis_tdata
);

  logic [FV_W-1:0]     out_value;
  logic [STATUS_W-1:0] out_status;
  logic                eval_taken;
  logic                write_taken;

  assign out_value   = m_axis_tdata[FV_W-1:0];
  assign out_status  = m_axis_tdata[FV_W+STATUS_W-1:FV_W];
  assign eval_taken  = s_axis_tvalid && s_axis_tready && (s_axis_tuser == KIND_EVAL);
  assign write_taken = s_axis_tvalid && s_axis_tready && (s_axis_tuser == KIND_WRITE);

  `HAAR_ASSERT_NEXT(a_out_hold, clk, rst, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))
  `HAAR_ASSERT_NEXT(a_eval_busy, clk, rst, eval_taken, !s_axis_tready)
  `HAAR_ASSERT_NEXT(a_write_stream, clk, rst, write_taken, s_axis_tready)
  `HAAR_ASSERT_SAME(a_error_zero, clk, rst, m_axis_tvalid && (out_status != ST_OK), (out_value == '0) && ((out_status == ST_INVALID) || (out_status == ST_OUTSIDE)))

endmodule

bind haar_feature_evaluator haar_checker u_haar_checker (.*);

@@ tb/sv/haar_feature_evaluator_checker.sv @@
module haar_feature_evaluator_checker
  import haar_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_axis_tvalid,
  input  logic                  s_axis_tready,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  input  logic                  s_axis_tuser,
  input  logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  input  logic [OUT_DATA_W-1:0] m_axis_tdata,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    pending,
  output int                    mismatches
);
  timeunit 1ns;
  timeprecision 1ps;

  // input word layout, lowest bit first
  localparam int IDX_LSB  = 0;
  localparam int VAL_LSB  = IDX_LSB + IDX_W;
  localparam int TYPE_LSB = VAL_LSB + VAL_IN_W;
  localparam int FX_LSB   = TYPE_LSB + TYPE_W;
  localparam int FY_LSB   = FX_LSB + OFS_W;
  localparam int FW_LSB   = FY_LSB + OFS_W;
  localparam int FH_LSB   = FW_LSB + SIZE_W;
  localparam int PX_LSB   = FH_LSB + SIZE_W;
  localparam int PY_LSB   = PX_LSB + OFS_W;

  localparam int STORE_DEPTH = DEF_MAX_WIDTH * DEF_MAX_HEIGHT;

  typedef struct packed {
    logic [STATUS_W-1:0]    status;
    logic signed [FV_W-1:0] value;
  } feat_result_t;

  logic [DEF_SUM_BITS-1:0] integral_img [STORE_DEPTH];
  logic [CFG_DATA_W-1:0]   width_reg  = IMAGE_SIZE_RST;
  logic [CFG_DATA_W-1:0]   height_reg = IMAGE_SIZE_RST;
  feat_result_t            pending_features [$];
  int                      bad_results = 0;

  function automatic longint tap(input int unsigned row, input int unsigned col,
                                 input int unsigned stride);
    int unsigned addr;
    addr = row * stride + col;
    if (addr >= STORE_DEPTH) return 0;
    return longint'(integral_img[addr]);
  endfunction

  // rectangle sum from four integral corners; row or column -1 reads as zero
  function automatic longint box_sum(input int unsigned x, input int unsigned y,
                                     input int unsigned w, input int unsigned h,
                                     input int unsigned stride);
    longint s;
    if (w == 0 || h == 0) return 0;
    s = tap(y + h - 1, x + w - 1, stride);
    if (x > 0) s -= tap(y + h - 1, x - 1, stride);
    if (y > 0) s -= tap(y - 1, x + w - 1, stride);
    if (x > 0 && y > 0) s += tap(y - 1, x - 1, stride);
    return s;
  endfunction

  function automatic feat_result_t evaluate_feature(input logic [IN_DATA_W-1:0] d);
    logic [TYPE_W-1:0] ftype;
    int unsigned       x0, y0, w, h, dx, dy, span_w, span_h, lim_w, lim_h;
    longint            v;
    feat_result_t      r;
    ftype  = d[TYPE_LSB +: TYPE_W];
    x0     = d[PX_LSB +: OFS_W];
    x0    += d[FX_LSB +: OFS_W];
    y0     = d[PY_LSB +: OFS_W];
    y0    += d[FY_LSB +: OFS_W];
    w      = d[FW_LSB +: SIZE_W];
    h      = d[FH_LSB +: SIZE_W];
    r.value = '0;
    if (ftype > FT_CROSS) begin
      r.status = ST_INVALID;
      return r;
    end
    // registers above the store geometry clamp to it
    lim_w = (width_reg < DEF_MAX_WIDTH) ? width_reg : DEF_MAX_WIDTH;
    lim_h = (height_reg < DEF_MAX_HEIGHT) ? height_reg : DEF_MAX_HEIGHT;
    dx = w;
    dy = h;
    span_w = w;
    span_h = h;
    case (ftype)
      FT_VERT2: begin
        dx = w / 2;
        span_w = 2 * dx;
      end
      FT_HORIZ2: begin
        dy = h / 2;
        span_h = 2 * dy;
      end
      FT_VERT3: begin
        dx = w / 3;
        span_w = 3 * dx;
      end
      FT_HORIZ3: begin
        dy = h / 3;
        span_h = 3 * dy;
      end
      default: begin
        dx = w / 2;
        dy = h / 2;
        span_w = 2 * dx;
        span_h = 2 * dy;
      end
    endcase
    if (x0 + span_w > lim_w || y0 + span_h > lim_h) begin
      r.status = ST_OUTSIDE;
      return r;
    end
    case (ftype)
      FT_VERT2:
        v = box_sum(x0, y0, dx, h, lim_w) - box_sum(x0 + dx, y0, dx, h, lim_w);
      FT_HORIZ2:
        v = box_sum(x0, y0, w, dy, lim_w) - box_sum(x0, y0 + dy, w, dy, lim_w);
      FT_VERT3:
        v = box_sum(x0 + dx, y0, dx, h, lim_w) - box_sum(x0, y0, dx, h, lim_w)
            - box_sum(x0 + 2 * dx, y0, dx, h, lim_w);
      FT_HORIZ3:
        v = box_sum(x0, y0 + dy, w, dy, lim_w) - box_sum(x0, y0, w, dy, lim_w)
            - box_sum(x0, y0 + 2 * dy, w, dy, lim_w);
      default:
        v = box_sum(x0, y0, dx, dy, lim_w) + box_sum(x0 + dx, y0 + dy, dx, dy, lim_w)
            - box_sum(x0 + dx, y0, dx, dy, lim_w) - box_sum(x0, y0 + dy, dx, dy, lim_w);
    endcase
    if (v > VALUE_MAX) v = VALUE_MAX;
    if (v < VALUE_MIN) v = VALUE_MIN;
    r.value  = v[FV_W-1:0];
    r.status = ST_OK;
    return r;
  endfunction

  always @(posedge clk) begin : watch
    feat_result_t want, got;
    if (rst) begin
      width_reg  = IMAGE_SIZE_RST;
      height_reg = IMAGE_SIZE_RST;
    end else begin
      if (cfg_we) begin
        if (cfg_index == REG_IMAGE_WIDTH) width_reg = cfg_data;
        else if (cfg_index == REG_IMAGE_HEIGHT) height_reg = cfg_data;
      end
      if (s_axis_tvalid && s_axis_tready) begin
        if (s_axis_tuser == KIND_WRITE)
          integral_img[s_axis_tdata[IDX_LSB +: IDX_W]] = s_axis_tdata[VAL_LSB +: VAL_IN_W];
        else
          pending_features = {pending_features, evaluate_feature(s_axis_tdata)};
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got.value  = m_axis_tdata[FV_W-1:0];
        got.status = m_axis_tdata[FV_W +: STATUS_W];
        if (pending_features.size() == 0) begin
          $display("%0t: result word with no evaluation outstanding: value %0d status %0d",
                   $time, $signed(got.value), got.status);
          bad_results++;
        end else begin
          want = pending_features.pop_front();
          if (want.value != got.value || want.status != got.status) begin
            $display("%0t: feature mismatch: expected value %0d status %0d,",
                     $time, $signed(want.value), want.status);
            $display("%0t:   got value %0d status %0d",
                     $time, $signed(got.value), got.status);
            bad_results++;
          end
        end
      end
    end
    pending    <= pending_features.size();
    mismatches <= bad_results;
  end

endmodule

@@ tb/sv/testbench.sv @@
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import haar_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SETTLE_CYCLES  = 25;
  localparam int PHASE_COUNT    = 12;
  localparam int PHASE_ITEMS    = 55;
  // every image size used below reads only below this store index
  localparam int FILL_DEPTH     = 512;
  localparam logic [DEF_SUM_BITS-1:0] SUM_FULL = '1;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic                  s_axis_tuser = KIND_WRITE;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = REG_IMAGE_WIDTH;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  int results_pending;
  int mismatch_count;
  int idle_cycles = 0;
  int stall_left = 0;
  bit calm = 1'b0;
  int eff_w = DEF_MAX_WIDTH;
  int eff_h = DEF_MAX_HEIGHT;
  int n_writes = 0;
  int n_evals = 0;

  haar_feature_evaluator i_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  haar_feature_evaluator_checker i_checker (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .pending       (results_pending),
    .mismatches    (mismatch_count)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // mostly short gaps, now and then a long one
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [DEF_SUM_BITS-1:0] entry_pattern();
    int r;
    r = $urandom_range(0, 9);
    if (r < 3) return SUM_FULL;
    if (r < 5) return '0;
    return DEF_SUM_BITS'($urandom);
  endfunction

  always @(posedge clk) begin
    if (stall_left > 0) begin
      m_axis_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      m_axis_tready <= 1'b1;
      stall_left <= calm ? 0 : idle_len();
    end
  end

  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no word moved for %0d cycles", $time, idle_cycles);
      $display("haar_feature_evaluator verification failed");
      $finish;
    end
  end

  // valid stays high straight into the next word when no gap is drawn
  task automatic push_word(input logic kind, input logic [IN_DATA_W-1:0] data);
    int gap;
    gap = calm ? 0 : idle_len();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= kind;
    s_axis_tdata  <= data;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
  endtask

  task automatic send_write(input logic [IDX_W-1:0] idx, input logic [VAL_IN_W-1:0] val);
    push_word(KIND_WRITE, {{(IN_DATA_W - IDX_W - VAL_IN_W){1'b0}}, val, idx});
    n_writes++;
  endtask

  task automatic send_eval(input logic [TYPE_W-1:0] ft, input logic [OFS_W-1:0] fx,
                           input logic [OFS_W-1:0] fy, input logic [SIZE_W-1:0] w,
                           input logic [SIZE_W-1:0] h, input logic [OFS_W-1:0] px,
                           input logic [OFS_W-1:0] py);
    push_word(KIND_EVAL, {3'b000, py, px, h, w, fy, fx, ft,
                          {(VAL_IN_W + IDX_W){1'b0}}});
    n_evals++;
  endtask

  // wait for the block to drain before touching the image registers
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (results_pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_size(input int w, input int h);
    cfg_we    <= 1'b1;
    cfg_index <= REG_IMAGE_WIDTH;
    cfg_data  <= CFG_DATA_W'(w);
    @(posedge clk);
    cfg_index <= REG_IMAGE_HEIGHT;
    cfg_data  <= CFG_DATA_W'(h);
    @(posedge clk);
    cfg_we <= 1'b0;
    eff_w = (w > DEF_MAX_WIDTH) ? DEF_MAX_WIDTH : w;
    eff_h = (h > DEF_MAX_HEIGHT) ? DEF_MAX_HEIGHT : h;
  endtask

  // size and origin along one axis so that the covered span fits the image
  function automatic void fit_axis(input int lim, input int fac, output int sz,
                                   output int win, output int ofs);
    int cap, part, org;
    cap  = ($urandom_range(0, 1) && lim > 8) ? 8 : lim;
    part = $urandom_range(0, cap / fac);
    sz   = part * fac + $urandom_range(0, fac - 1);
    org  = $urandom_range(0, lim - part * fac);
    win  = $urandom_range(org > 63 ? org - 63 : 0, org < 63 ? org : 63);
    ofs  = org - win;
  endfunction

  task automatic random_item();
    int                sel, xf, yf, w, h, px, py, fx, fy;
    logic [TYPE_W-1:0] ft;
    sel = $urandom_range(0, 99);
    if (sel < 25) begin
      send_write(IDX_W'($urandom_range(0, FILL_DEPTH - 1)), entry_pattern());
    end else if (sel < 33) begin
      send_eval(TYPE_W'($urandom_range(FT_CROSS + 1, 7)), OFS_W'($urandom),
                OFS_W'($urandom), SIZE_W'($urandom), SIZE_W'($urandom),
                OFS_W'($urandom), OFS_W'($urandom));
    end else if (sel < 43) begin
      send_eval(TYPE_W'($urandom), OFS_W'($urandom), OFS_W'($urandom),
                SIZE_W'($urandom), SIZE_W'($urandom), OFS_W'($urandom),
                OFS_W'($urandom));
    end else begin
      ft = TYPE_W'($urandom_range(FT_VERT2, FT_CROSS));
      xf = (ft == FT_VERT3) ? 3 : (ft == FT_VERT2 || ft == FT_CROSS) ? 2 : 1;
      yf = (ft == FT_HORIZ3) ? 3 : (ft == FT_HORIZ2 || ft == FT_CROSS) ? 2 : 1;
      fit_axis(eff_w, xf, w, px, fx);
      fit_axis(eff_h, yf, h, py, fy);
      send_eval(ft, OFS_W'(fx), OFS_W'(fy), SIZE_W'(w), SIZE_W'(h),
                OFS_W'(px), OFS_W'(py));
    end
  endtask

  initial begin
    int widths [PHASE_COUNT];
    int heights [PHASE_COUNT];
    widths  = '{64, 1, 64, 1, 8, 127, 0, 20, 5, 37, 0, 0};
    heights = '{8, 1, 1, 64, 8, 5, 5, 13, 100, 13, 0, 0};
    widths[10]  = $urandom_range(1, 64);
    heights[10] = $urandom_range(1, (FILL_DEPTH / widths[10] > 64) ? 64
                                                                   : FILL_DEPTH / widths[10]);
    widths[11]  = $urandom_range(1, 64);
    heights[11] = $urandom_range(1, (FILL_DEPTH / widths[11] > 64) ? 64
                                                                   : FILL_DEPTH / widths[11]);

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    set_size(widths[0], heights[0]);

    // fill the low store entries so every later read hits a written entry
    for (int i = 0; i < FILL_DEPTH; i++) send_write(IDX_W'(i), entry_pattern());

    // alternating full/zero corners drive vert3 past both saturation limits
    for (int pol = 1; pol >= 0; pol--) begin
      for (int i = 0; i < 8; i++)
        send_write(IDX_W'((i / 4) * DEF_MAX_WIDTH + i % 4),
                   (((i / 4) + (i % 4)) % 2 == pol) ? SUM_FULL : '0);
      send_eval(FT_VERT3, 0, 0, 3, 1, 1, 1);
    end

    // whole-image features of every type
    send_eval(FT_VERT2, 0, 0, 64, 8, 0, 0);
    send_eval(FT_HORIZ2, 0, 0, 64, 8, 0, 0);
    send_eval(FT_VERT3, 0, 0, 64, 8, 0, 0);
    send_eval(FT_HORIZ3, 0, 0, 64, 8, 0, 0);
    send_eval(FT_CROSS, 0, 0, 64, 8, 0, 0);
    // empty parts at the far offsets, then the last row and column
    send_eval(FT_VERT2, 63, 7, 1, 1, 0, 0);
    send_eval(FT_HORIZ3, 0, 0, 1, 1, 63, 7);
    send_eval(FT_HORIZ2, 0, 0, 1, 2, 63, 6);
    // one past the edge, and an oversized part
    send_eval(FT_VERT2, 0, 0, 2, 1, 63, 0);
    send_eval(FT_HORIZ3, 0, 0, 1, 66, 0, 0);
    send_eval(FT_HORIZ2, 0, 0, 127, 2, 0, 0);
    // unknown types, one with every other field at its top and one with all zero
    send_eval(3'd5, 63, 63, 127, 127, 63, 63);
    send_eval(3'd7, 0, 0, 0, 0, 0, 0);

    for (int p = 0; p < PHASE_COUNT; p++) begin
      if (p > 0) begin
        settle();
        set_size(widths[p], heights[p]);
      end
      calm = (p % 4 == 2);
      repeat (PHASE_ITEMS) random_item();
    end

    calm = 1'b0;
    settle();
    $display("covered %0d store writes and %0d feature evaluations", n_writes, n_evals);
    $display("over %0d image sizes, clamped and zero sizes included", PHASE_COUNT);
    if (mismatch_count == 0 && results_pending == 0)
      $display("haar_feature_evaluator verification clean");
    else
      $display("haar_feature_evaluator verification failed");
    $finish;
  end

endmodule
